### rtl/lpm_pkg.sv
// Shared types, widths and codes for the route and ARP lookup block.
// Used by lpm_front, lpm_back and the top level lpm_route_and_arp_lookup.
// Has no dependencies of its own.
`default_nettype none

package lpm_pkg;

  localparam int ADDR_W = 32;
  localparam int MAC_W = 48;
  localparam int PORT_W = 2;
  localparam int IDX_W = 7;
  localparam int MODE_W = 2;
  localparam int CNT_W = 8;
  localparam int LEN_W = 6;
  localparam int CFG_IDX_W = 8;

  localparam int ROUTE_DEPTH_DEF = 128;
  localparam int ARP_DEPTH_DEF = 128;
  localparam int QUEUE_DEPTH = 2;

  // Input mode codes.
  localparam logic [MODE_W-1:0] MODE_ROUTE_WR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ARP_WR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROUTE_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARP_COUNT = 8'd1;

  typedef enum logic [1:0] {
    OP_ROUTE_WR = 2'd0,
    OP_ARP_WR   = 2'd1,
    OP_LOOKUP   = 2'd2
  } op_t;

  // One classified word handed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
    logic [MAC_W-1:0]  mac;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } route_ent_t;

  typedef struct packed {
    logic [ADDR_W-1:0] ip;
    logic [MAC_W-1:0]  mac;
  } arp_ent_t;

  // Handshake between the front queue and the back.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

`default_nettype wire

### rtl/lpm_front.sv
// Front part: accepts input words, classifies them and queues them for the back.
// Depends on lpm_pkg for the command type, mode codes and queue depth.
`default_nettype none

module lpm_front #(
  parameter int ROUTE_DEPTH = lpm_pkg::ROUTE_DEPTH_DEF,
  parameter int ARP_DEPTH = lpm_pkg::ARP_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lpm_pkg::MODE_W-1:0]    mode,
  input  wire logic [lpm_pkg::IDX_W-1:0]     entry_index,
  input  wire logic [lpm_pkg::ADDR_W-1:0]    route_prefix_in,
  input  wire logic [lpm_pkg::ADDR_W-1:0]    route_mask_in,
  input  wire logic [lpm_pkg::ADDR_W-1:0]    route_hop_in,
  input  wire logic [lpm_pkg::PORT_W-1:0]    route_port_in,
  input  wire logic [lpm_pkg::ADDR_W-1:0]    addr_in,
  input  wire logic [lpm_pkg::MAC_W-1:0]     mac_in,
  output lpm_pkg::cmd_chan_t                 cmd_out,
  input  wire logic                          cmd_take
);

  localparam int QD = lpm_pkg::QUEUE_DEPTH;
  localparam int QW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  lpm_pkg::cmd_t queue [QD];
  logic [QW-1:0]  wr_ptr;
  logic [QW-1:0]  rd_ptr;
  logic [QCW-1:0] fill;

  lpm_pkg::cmd_t cmd_new;
  logic          keep;
  logic          accept;
  logic          push;

  // Mode three and writes past the end of a table leave no trace.
  always_comb begin
    cmd_new.idx = entry_index;
    cmd_new.prefix = route_prefix_in;
    cmd_new.mask = route_mask_in;
    cmd_new.hop = route_hop_in;
    cmd_new.port = route_port_in;
    cmd_new.addr = addr_in;
    cmd_new.mac = mac_in;
    unique case (mode)
      lpm_pkg::MODE_ROUTE_WR: begin
        cmd_new.op = lpm_pkg::OP_ROUTE_WR;
        keep = 32'(entry_index) < 32'(ROUTE_DEPTH);
      end
      lpm_pkg::MODE_ARP_WR: begin
        cmd_new.op = lpm_pkg::OP_ARP_WR;
        keep = 32'(entry_index) < 32'(ARP_DEPTH);
      end
      lpm_pkg::MODE_LOOKUP: begin
        cmd_new.op = lpm_pkg::OP_LOOKUP;
        keep = 1'b1;
      end
      default: begin
        cmd_new.op = lpm_pkg::OP_LOOKUP;
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = (fill == QCW'(QD));
  assign accept = in_valid && !in_stall;
  assign push = accept && keep;

  assign cmd_out.valid = (fill != '0);
  assign cmd_out.cmd = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= (rd_ptr == QW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !cmd_take) begin
        fill <= fill + 1'b1;
      end else if (!push && cmd_take) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/lpm_back.sv
// Back part: holds the route and ARP memories, executes writes and runs the
// two linear scans of a lookup, then presents the result in an output register.
// Depends on lpm_pkg for the command, entry types and widths.
`default_nettype none

module lpm_back #(
  parameter int ROUTE_DEPTH = lpm_pkg::ROUTE_DEPTH_DEF,
  parameter int ARP_DEPTH = lpm_pkg::ARP_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lpm_pkg::cmd_chan_t            cmd_in,
  output logic                               cmd_take,
  input  wire logic [lpm_pkg::CNT_W-1:0]     route_count,
  input  wire logic [lpm_pkg::CNT_W-1:0]     arp_count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               route_found,
  output logic                               arp_found,
  output logic [lpm_pkg::ADDR_W-1:0]         hop_out,
  output logic [lpm_pkg::PORT_W-1:0]         port_out,
  output logic [lpm_pkg::MAC_W-1:0]          mac_out
);

  localparam int RAW = $clog2(ROUTE_DEPTH);
  localparam int AAW = $clog2(ARP_DEPTH);
  localparam int RCW = $clog2(ROUTE_DEPTH + 1);
  localparam int ACW = $clog2(ARP_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RSCAN = 4'b0010,
    ST_ASCAN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  // Balanced adder tree for the mask length.
  function automatic logic [lpm_pkg::LEN_W-1:0] ones32(input logic [31:0] v);
    logic [1:0] s1 [16];
    logic [2:0] s2 [8];
    logic [3:0] s3 [4];
    logic [4:0] s4 [2];
    for (int i = 0; i < 16; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 8; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 4; i++) s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 2; i++) s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    return {1'b0, s4[0]} + {1'b0, s4[1]};
  endfunction

  lpm_pkg::route_ent_t route_mem [ROUTE_DEPTH];
  lpm_pkg::arp_ent_t   arp_mem [ARP_DEPTH];
  lpm_pkg::route_ent_t route_rd;
  lpm_pkg::arp_ent_t   arp_rd;

  state_t                       state;
  logic [RCW-1:0]               r_idx;
  logic [RCW-1:0]               r_num;
  logic [ACW-1:0]               a_idx;
  logic [ACW-1:0]               a_num;
  logic                         rd_pending;
  logic [lpm_pkg::ADDR_W-1:0]   dst_addr;
  logic [lpm_pkg::LEN_W-1:0]    best_len;
  logic                         res_route_found;
  logic                         res_arp_found;
  logic [lpm_pkg::ADDR_W-1:0]   res_hop;
  logic [lpm_pkg::PORT_W-1:0]   res_port;
  logic [lpm_pkg::MAC_W-1:0]    res_mac;

  logic [RCW-1:0]               r_lim;
  logic [ACW-1:0]               a_lim;
  logic                         route_we;
  logic                         arp_we;
  logic                         route_hit;
  logic [lpm_pkg::LEN_W-1:0]    route_len;
  lpm_pkg::route_ent_t          route_wr;
  lpm_pkg::arp_ent_t            arp_wr;

  // Scan lengths saturate at the table depth.
  assign r_lim = (32'(route_count) > 32'(ROUTE_DEPTH)) ? RCW'(ROUTE_DEPTH) : RCW'(route_count);
  assign a_lim = (32'(arp_count) > 32'(ARP_DEPTH)) ? ACW'(ARP_DEPTH) : ACW'(arp_count);

  assign cmd_take = (state == ST_IDLE) && cmd_in.valid;
  assign route_we = cmd_take && (cmd_in.cmd.op == lpm_pkg::OP_ROUTE_WR);
  assign arp_we = cmd_take && (cmd_in.cmd.op == lpm_pkg::OP_ARP_WR);

  assign route_wr.prefix = cmd_in.cmd.prefix;
  assign route_wr.mask = cmd_in.cmd.mask;
  assign route_wr.hop = cmd_in.cmd.hop;
  assign route_wr.port = cmd_in.cmd.port;
  assign arp_wr.ip = cmd_in.cmd.addr;
  assign arp_wr.mac = cmd_in.cmd.mac;

  always_ff @(posedge clk) begin
    if (route_we) begin
      route_mem[RAW'(cmd_in.cmd.idx)] <= route_wr;
    end
    route_rd <= route_mem[r_idx[RAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (arp_we) begin
      arp_mem[AAW'(cmd_in.cmd.idx)] <= arp_wr;
    end
    arp_rd <= arp_mem[a_idx[AAW-1:0]];
  end

  assign route_hit = ((route_rd.prefix ^ dst_addr) & route_rd.mask) == '0;
  assign route_len = ones32(route_rd.mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_pending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // In the done state the result load below decides out_valid.
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_take && cmd_in.cmd.op == lpm_pkg::OP_LOOKUP) begin
            dst_addr <= cmd_in.cmd.addr;
            r_num <= r_lim;
            a_num <= a_lim;
            r_idx <= '0;
            a_idx <= '0;
            rd_pending <= 1'b0;
            best_len <= '0;
            res_route_found <= 1'b0;
            res_arp_found <= 1'b0;
            res_hop <= '0;
            res_port <= '0;
            res_mac <= '0;
            state <= ST_RSCAN;
          end
        end
        ST_RSCAN: begin
          if (r_idx != r_num) begin
            r_idx <= r_idx + 1'b1;
            rd_pending <= 1'b1;
          end else begin
            rd_pending <= 1'b0;
          end
          // Only a strictly longer mask displaces an earlier match.
          if (rd_pending && route_hit && (!res_route_found || route_len > best_len)) begin
            res_route_found <= 1'b1;
            best_len <= route_len;
            res_hop <= route_rd.hop;
            res_port <= route_rd.port;
          end
          if (r_idx == r_num && !rd_pending) begin
            if (res_route_found && a_num != '0) begin
              state <= ST_ASCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_ASCAN: begin
          // The first ARP hit ends the scan.
          if (rd_pending && arp_rd.ip == res_hop) begin
            res_arp_found <= 1'b1;
            res_mac <= arp_rd.mac;
            rd_pending <= 1'b0;
            state <= ST_DONE;
          end else begin
            if (a_idx != a_num) begin
              a_idx <= a_idx + 1'b1;
              rd_pending <= 1'b1;
            end else begin
              rd_pending <= 1'b0;
            end
            if (a_idx == a_num && !rd_pending) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            route_found <= res_route_found;
            arp_found <= res_arp_found;
            hop_out <= res_hop;
            port_out <= res_port;
            mac_out <= res_mac;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/lpm_route_and_arp_lookup.sv
// Longest prefix match over a linear route table, followed by an ARP lookup.
// A write word is written to its table when the back part takes it. A lookup scans the
// route table and then the ARP table, one table entry per cycle through each memory's
// single read port, and then loads the output register; lookups run one at a time, a
// lookup with no route skips the ARP scan, and an ARP hit ends it early.
// Synchronous active-high reset clears the queue, controller and both count registers.
`default_nettype none

module lpm_route_and_arp_lookup #(
  parameter int ROUTE_DEPTH = lpm_pkg::ROUTE_DEPTH_DEF,
  parameter int ARP_DEPTH = lpm_pkg::ARP_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [lpm_pkg::MODE_W-1:0]      mode,
  input  wire logic [lpm_pkg::IDX_W-1:0]       entry_index,
  input  wire logic [lpm_pkg::ADDR_W-1:0]      route_prefix_in,
  input  wire logic [lpm_pkg::ADDR_W-1:0]      route_mask_in,
  input  wire logic [lpm_pkg::ADDR_W-1:0]      route_hop_in,
  input  wire logic [lpm_pkg::PORT_W-1:0]      route_port_in,
  input  wire logic [lpm_pkg::ADDR_W-1:0]      addr_in,
  input  wire logic [lpm_pkg::MAC_W-1:0]       mac_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 route_found,
  output logic                                 arp_found,
  output logic [lpm_pkg::ADDR_W-1:0]           hop_out,
  output logic [lpm_pkg::PORT_W-1:0]           port_out,
  output logic [lpm_pkg::MAC_W-1:0]            mac_out,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lpm_pkg::CNT_W-1:0]       cfg_data
);

  logic [lpm_pkg::CNT_W-1:0] route_count;
  logic [lpm_pkg::CNT_W-1:0] arp_count;
  lpm_pkg::cmd_chan_t        cmd_chan;
  logic                      cmd_take;

  assign cfg_ready = 1'b1;

  // Writes to unknown register indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
      arp_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpm_pkg::REG_ROUTE_COUNT: begin
          route_count <= cfg_data;
        end
        lpm_pkg::REG_ARP_COUNT: begin
          arp_count <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  lpm_front #(
    .ROUTE_DEPTH(ROUTE_DEPTH),
    .ARP_DEPTH(ARP_DEPTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .entry_index(entry_index),
    .route_prefix_in(route_prefix_in),
    .route_mask_in(route_mask_in),
    .route_hop_in(route_hop_in),
    .route_port_in(route_port_in),
    .addr_in(addr_in),
    .mac_in(mac_in),
    .cmd_out(cmd_chan),
    .cmd_take(cmd_take)
  );

  lpm_back #(
    .ROUTE_DEPTH(ROUTE_DEPTH),
    .ARP_DEPTH(ARP_DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_in(cmd_chan),
    .cmd_take(cmd_take),
    .route_count(route_count),
    .arp_count(arp_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .route_found(route_found),
    .arp_found(arp_found),
    .hop_out(hop_out),
    .port_out(port_out),
    .mac_out(mac_out)
  );

  // A full queue always has a word for the back to see.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> cmd_chan.valid)
    else $error("input stalled while the queue is empty");

  // The back never loads a result in the same cycle it takes a new word.
  a_result_not_while_taking: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!cmd_take))
    else $error("result loaded while a word was taken");

  a_arp_needs_route: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!arp_found || route_found))
    else $error("ARP hit reported without a route");

  a_no_route_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !route_found) |-> (hop_out == '0 && port_out == '0 && mac_out == '0))
    else $error("nonzero fields on a lookup without a route");

endmodule

`default_nettype wire
